@@ hdl/lz78_pkg.sv @@
`default_nettype none
// ============================================================================
// lz78_pkg: shared constants and types of the LZ78 decoder
// Dictionary and phrase limits, field widths, dictionary entry layout and the
// command and status groups between controller and datapath.
// ============================================================================
package lz78_pkg;

   localparam int DICT_DEPTH = 4096;
   localparam int MAX_PHRASE = 64;

   localparam int IDX_W   = 12;
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 6;
   localparam int COUNT_W = 13;
   localparam int ADDR_W  = $clog2(DICT_DEPTH);
   localparam int STK_W   = $clog2(MAX_PHRASE);

   typedef struct packed {
      logic [IDX_W-1:0]  parent;
      logic [BYTE_W-1:0] tail;
      logic [LEN_W-1:0]  length;
   } dict_entry_type;

   typedef struct packed {
      logic load;
      logic walk_step;
      logic walk_first;
      logic dict_write;
      logic emit_start;
   } cmd_type;

   typedef struct packed {
      logic need_walk;
      logic walk_last;
      logic emit_done;
   } status_type;

endpackage
`default_nettype wire

@@ hdl/lz78_if.sv @@
`default_nettype none
// ============================================================================
// lz78_if: channel interfaces of the LZ78 decoder
// Code pair channel and decoded byte channel, valid/ready handshake.
// ============================================================================
interface lz78_req_if;
   logic                        valid;
   logic                        ready;
   logic [lz78_pkg::IDX_W-1:0]  phrase_index;
   logic [lz78_pkg::BYTE_W-1:0] next_byte;

   modport source (output valid, output phrase_index, output next_byte, input ready);
   modport sink   (input valid, input phrase_index, input next_byte, output ready);
endinterface

interface lz78_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lz78_pkg::BYTE_W-1:0] out_byte;
   logic                        last_of_run;
   logic                        bad_index;

   modport source (output valid, output out_byte, output last_of_run, output bad_index,
                   input ready);
   modport sink   (input valid, input out_byte, input last_of_run, input bad_index,
                   output ready);
endinterface
`default_nettype wire

@@ hdl/lz78_ctrl.sv @@
`default_nettype none
// ============================================================================
// lz78_ctrl: LZ78 decoder controller
// Sequences accept, parent walk, dictionary update and byte emission.
// ============================================================================
module lz78_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire lz78_pkg::status_type status,
   output lz78_pkg::cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_UPDATE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      first_ff, first_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      first_in = first_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            ready_in = 1'b1;
            if (req_valid && ready_ff) begin
               cmd.load = 1'b1;
               ready_in = 1'b0;
               first_in = 1'b1;
               state_in = status.need_walk ? ST_WALK : ST_UPDATE;
            end
         end
         ST_WALK: begin
            cmd.walk_step  = 1'b1;
            cmd.walk_first = first_ff;
            first_in       = 1'b0;
            if (status.walk_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.dict_write = 1'b1;
            cmd.emit_start = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.emit_done) begin
               ready_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            ready_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         first_ff <= first_in;
      end
   end

   assign req_ready = ready_ff;

endmodule
`default_nettype wire

@@ hdl/lz78_dpath.sv @@
`default_nettype none
// ============================================================================
// lz78_dpath: LZ78 decoder datapath
// Dictionary memory, reverse stack memory, entry counter and the emit
// pipeline with its output register.
// ============================================================================
module lz78_dpath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lz78_pkg::cmd_type           cmd,
   output lz78_pkg::status_type             status,
   input  wire logic [lz78_pkg::IDX_W-1:0]  req_phrase_index,
   input  wire logic [lz78_pkg::BYTE_W-1:0] req_next_byte,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [lz78_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                             rsp_last_of_run,
   output logic                             rsp_bad_index
);

   localparam int IDX_W   = lz78_pkg::IDX_W;
   localparam int BYTE_W  = lz78_pkg::BYTE_W;
   localparam int LEN_W   = lz78_pkg::LEN_W;
   localparam int COUNT_W = lz78_pkg::COUNT_W;
   localparam int ADDR_W  = lz78_pkg::ADDR_W;
   localparam int STK_W   = lz78_pkg::STK_W;
   localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(lz78_pkg::MAX_PHRASE - 1);
   localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(lz78_pkg::DICT_DEPTH);

   // memories
   lz78_pkg::dict_entry_type dict_mem [lz78_pkg::DICT_DEPTH];
   logic [BYTE_W-1:0]        stack_mem [lz78_pkg::MAX_PHRASE];
   lz78_pkg::dict_entry_type dict_q_ff;
   logic [BYTE_W-1:0]        stack_q_ff;

   // item registers
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               bad_ff, bad_in;
   logic [LEN_W-1:0]   plen_ff, plen_in;
   logic [LEN_W-1:0]   wpos_ff, wpos_in;

   // emit pipeline
   logic [LEN_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              rd_more_ff, rd_more_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              rd_lit_ff, rd_lit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_bad_ff, rsp_bad_in;

   logic                     bad_now;
   logic                     dict_re;
   logic [ADDR_W-1:0]        dict_raddr;
   lz78_pkg::dict_entry_type dict_wdata;
   logic                     dict_we;
   logic [LEN_W-1:0]         len_clamped;
   logic [LEN_W-1:0]         cur_plen;
   logic [LEN_W-1:0]         pos;
   logic                     load_out;
   logic                     re_step;
   logic                     rd_hit_lit;
   logic                     stack_re;

   always_comb begin
      bad_now = (req_phrase_index != '0) && (COUNT_W'(req_phrase_index) > count_ff);

      // parent walk
      len_clamped = (dict_q_ff.length > LEN_MAX) ? LEN_MAX : dict_q_ff.length;
      cur_plen    = cmd.walk_first ? len_clamped : plen_ff;
      pos         = cmd.walk_first ? (len_clamped - LEN_W'(1)) : wpos_ff;

      dict_re    = cmd.load || cmd.walk_step;
      dict_raddr = cmd.load ? ADDR_W'(req_phrase_index - IDX_W'(1))
                            : ADDR_W'(dict_q_ff.parent - IDX_W'(1));

      // dictionary update
      dict_we           = cmd.dict_write && (count_ff < COUNT_CAP) && (plen_ff < LEN_MAX);
      dict_wdata.parent = bad_ff ? '0 : idx_ff;
      dict_wdata.tail   = byte_ff;
      dict_wdata.length = plen_ff + LEN_W'(1);

      // emit pipeline
      rd_hit_lit = (rd_idx_ff == plen_ff);
      load_out   = rd_valid_ff && (!rsp_valid_ff || rsp_ready);
      re_step    = rd_more_ff && (!rd_valid_ff || load_out);
      stack_re   = re_step && !rd_hit_lit;

      status.need_walk = (req_phrase_index != '0) && !bad_now;
      status.walk_last = (pos == '0);
      status.emit_done = !rd_more_ff && !rd_valid_ff;
   end

   always_comb begin
      count_in = dict_we ? (count_ff + COUNT_W'(1)) : count_ff;
      idx_in   = cmd.load ? req_phrase_index : idx_ff;
      byte_in  = cmd.load ? req_next_byte : byte_ff;
      bad_in   = cmd.load ? bad_now : bad_ff;

      plen_in = plen_ff;
      wpos_in = wpos_ff;
      if (cmd.load) begin
         plen_in = '0;
      end else if (cmd.walk_step) begin
         plen_in = cur_plen;
         wpos_in = pos - LEN_W'(1);
      end

      rd_idx_in   = rd_idx_ff;
      rd_more_in  = rd_more_ff;
      rd_valid_in = rd_valid_ff;
      rd_lit_in   = rd_lit_ff;
      if (cmd.emit_start) begin
         rd_idx_in  = '0;
         rd_more_in = 1'b1;
      end else if (re_step) begin
         rd_valid_in = 1'b1;
         rd_lit_in   = rd_hit_lit;
         if (rd_hit_lit) begin
            rd_more_in = 1'b0;
         end else begin
            rd_idx_in = rd_idx_ff + LEN_W'(1);
         end
      end else if (load_out) begin
         rd_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = rd_lit_ff ? byte_ff : stack_q_ff;
         rsp_last_in  = rd_lit_ff;
         rsp_bad_in   = bad_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dict_we) begin
         dict_mem[ADDR_W'(count_ff)] <= dict_wdata;
      end
      if (dict_re) begin
         dict_q_ff <= dict_mem[dict_raddr];
      end
      if (cmd.walk_step) begin
         stack_mem[pos[STK_W-1:0]] <= dict_q_ff.tail;
      end
      if (stack_re) begin
         stack_q_ff <= stack_mem[rd_idx_ff[STK_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_more_ff   <= 1'b0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_more_ff   <= rd_more_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      byte_ff     <= byte_in;
      bad_ff      <= bad_in;
      plen_ff     <= plen_in;
      wpos_ff     <= wpos_in;
      rd_idx_ff   <= rd_idx_in;
      rd_lit_ff   <= rd_lit_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_bad_index   = rsp_bad_ff;

endmodule
`default_nettype wire

@@ hdl/lz78_decoder.sv @@
`default_nettype none
// ============================================================================
// lz78_decoder: LZ78 decompressor top level
// Expands code pairs (phrase index, next byte) into decoded bytes.
// ============================================================================
//  channel  | direction | transfer
//  ---------+-----------+-----------------------------------------------
//  req      | in        | one code pair: phrase_index, next_byte
//  rsp      | out       | one decoded byte: out_byte, last_of_run, bad_index
//
//  A pair with an n-byte phrase (n up to 63) passes these steps from one accept to
//  the next: accept, walk the parent links (one dictionary read per cycle), add
//  the new entry, then the n+1 bytes pass the stack read and output registers
//  at one per cycle while rsp is ready.
//  Reset clears control state and the entry count; no memory clear is needed.
//  A stalled rsp holds the byte pipeline; req.ready stays low until the last
//  byte of the pair has reached the output register.
module lz78_decoder (
   input wire logic   clock,
   input wire logic   reset,
   lz78_req_if.sink   req,
   lz78_rsp_if.source rsp
);

   lz78_pkg::cmd_type    cmd;
   lz78_pkg::status_type status;

   lz78_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lz78_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_phrase_index (req.phrase_index),
      .req_next_byte    (req.next_byte),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_out_byte     (rsp.out_byte),
      .rsp_last_of_run  (rsp.last_of_run),
      .rsp_bad_index    (rsp.bad_index)
   );

endmodule
`default_nettype wire
